// ----- sv/wss_pkg.sv -----
// Shared types, constants and helpers of the weighted sampler sum tree.
`timescale 1ns / 1ps
package wss_pkg;

	localparam int LEAVES       = 1024;
	localparam int LEVELS       = 10;
	localparam int NODE_BITS    = LEVELS + 1;
	localparam int TREE_DEPTH   = 2 * LEAVES;
	localparam int WEIGHT_BITS  = 32;
	localparam int UNIFORM_BITS = 32;
	localparam int SUM_BITS     = 42;
	localparam int LO_BITS      = 32;
	localparam int LO_PROD_BITS = UNIFORM_BITS + LO_BITS;
	localparam int HI_PROD_BITS = UNIFORM_BITS + SUM_BITS - LO_BITS;

	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_READ   = 2'd1;
	localparam logic [1:0] REQ_SAMPLE = 2'd2;
	localparam logic [1:0] REQ_NONE   = 2'd3;

	typedef struct packed {
		logic [1:0]              req_type;
		logic [LEVELS-1:0]       leaf_index;
		logic [WEIGHT_BITS-1:0]  new_weight;
		logic [UNIFORM_BITS-1:0] uniform_fraction;
		logic [LEVELS-1:0]       tie_bits;
	} req_t;

	typedef struct packed {
		logic [LEVELS-1:0]      chosen_index;
		logic [WEIGHT_BITS-1:0] leaf_weight;
		logic [SUM_BITS-1:0]    total_weight;
	} rsp_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_WLEAF,
		OP_WUP,
		OP_RLEAF,
		OP_RWAIT,
		OP_MUL,
		OP_SCALE,
		OP_DESC,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic root_next;
		logic leaf_next;
		logic at_leaf;
		logic out_free;
	} status_t;

	// Number of leaves under a node: the root covers all of them, each level halves it.
	function automatic logic [SUM_BITS-1:0] leaves_below(input logic [NODE_BITS-1:0] node);
		logic [SUM_BITS-1:0] res;
		res = '0;
		for (int i = 0; i < NODE_BITS; i++) begin
			if (node[i]) begin
				res = SUM_BITS'(LEAVES) >> i;
			end
		end
		return res;
	endfunction

endpackage

// ----- sv/wss_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module wss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/wss_ctrl.sv -----
// Sequencer of the sum tree: clearing pass, write path, read and sample descent.
`timescale 1ns / 1ps
module wss_ctrl import wss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_kind,
	output logic       req_ready,
	output cmd_t       cmd,
	input  status_t    status
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_WLEAF,
		S_WUP,
		S_RLEAF,
		S_RWAIT,
		S_MUL,
		S_SCALE,
		S_DESC,
		S_FINISH
	} state_t;

	state_t state_q;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_CLEAR:  cmd.op = OP_CLEAR;
			S_IDLE:   cmd.op = req_valid ? OP_LOAD : OP_NONE;
			S_WLEAF:  cmd.op = OP_WLEAF;
			S_WUP:    cmd.op = OP_WUP;
			S_RLEAF:  cmd.op = OP_RLEAF;
			S_RWAIT:  cmd.op = OP_RWAIT;
			S_MUL:    cmd.op = OP_MUL;
			S_SCALE:  cmd.op = OP_SCALE;
			S_DESC:   cmd.op = OP_DESC;
			S_FINISH: cmd.op = status.out_free ? OP_RESULT : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (status.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						unique case (req_kind)
							REQ_WRITE:  state_q <= S_WLEAF;
							REQ_READ:   state_q <= S_RLEAF;
							REQ_SAMPLE: state_q <= S_MUL;
							REQ_NONE:   state_q <= S_FINISH;
						endcase
					end
				end
				S_WLEAF: state_q <= S_WUP;
				S_WUP: begin
					if (status.root_next) state_q <= S_FINISH;
				end
				S_RLEAF: state_q <= S_RWAIT;
				S_RWAIT: state_q <= S_FINISH;
				S_MUL:   state_q <= S_SCALE;
				S_SCALE: state_q <= S_DESC;
				S_DESC: begin
					if (status.leaf_next) state_q <= S_RWAIT;
				end
				S_FINISH: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/wss_dp.sv -----
// Datapath of the sum tree: node memory, path registers, scaling multiply, result register.
`timescale 1ns / 1ps
module wss_dp import wss_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	output status_t status,
	input  req_t    req,
	output rsp_t    rsp,
	output logic    rsp_valid,
	input  logic    rsp_ready
);

	// Node n has children 2n and 2n+1; leaves sit at LEAVES + index.
	logic                    ram_we;
	logic [NODE_BITS-1:0]    ram_waddr;
	logic [SUM_BITS-1:0]     ram_wdata;
	logic [NODE_BITS-1:0]    ram_raddr;
	logic [SUM_BITS-1:0]     rd_data;

	logic [NODE_BITS-1:0]    clr_q;
	logic [SUM_BITS-1:0]     total_q;
	logic                    out_valid_q;

	req_t                    req_q;
	logic [NODE_BITS-1:0]    node_q;
	logic [SUM_BITS-1:0]     cur_q;
	logic [LEVELS-1:0]       tie_q;
	logic [LEVELS-1:0]       chosen_q;
	logic [WEIGHT_BITS-1:0]  wt_q;
	logic [LO_PROD_BITS-1:0] p_lo_s1;
	logic [HI_PROD_BITS-1:0] p_hi_s1;
	rsp_t                    out_q;

	logic [SUM_BITS-1:0]     sum;
	logic [NODE_BITS-1:0]    parent;
	logic                    go_right;
	logic [NODE_BITS-1:0]    node_next;
	logic [SUM_BITS-1:0]     scaled;

	wss_ram #(
		.WIDTH(SUM_BITS),
		.DEPTH(TREE_DEPTH)
	) u_tree (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	assign sum       = cur_q + rd_data;
	assign parent    = node_q >> 1;
	// During the descent cur_q holds the scaled draw and rd_data the left child's sum.
	assign go_right  = (cur_q > rd_data) || ((cur_q == rd_data) && tie_q[0]);
	assign node_next = {node_q[NODE_BITS-2:0], go_right};
	assign scaled    = SUM_BITS'(p_hi_s1)
	                 + SUM_BITS'(p_lo_s1[LO_PROD_BITS-1:UNIFORM_BITS]);

	assign status.clr_last  = (clr_q == NODE_BITS'(TREE_DEPTH - 1));
	assign status.root_next = (parent == NODE_BITS'(1));
	assign status.leaf_next = node_q[LEVELS-1];
	assign status.at_leaf   = node_q[LEVELS];
	assign status.out_free  = !out_valid_q || rsp_ready;

	assign rsp       = out_q;
	assign rsp_valid = out_valid_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = node_q;
		ram_wdata = cur_q;
		ram_raddr = node_q;
		unique case (cmd.op)
			OP_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = leaves_below(clr_q);
			end
			OP_WLEAF: begin
				ram_we    = 1'b1;
				ram_wdata = SUM_BITS'(req_q.new_weight);
				ram_raddr = node_q ^ NODE_BITS'(1);
			end
			OP_WUP: begin
				ram_we    = 1'b1;
				ram_waddr = parent;
				ram_wdata = sum;
				ram_raddr = parent ^ NODE_BITS'(1);
			end
			OP_SCALE: ram_raddr = NODE_BITS'(2);
			OP_DESC: begin
				// On the last level fetch the chosen leaf itself rather than a child.
				ram_raddr = status.leaf_next ? node_next
				                             : {node_next[NODE_BITS-2:0], 1'b0};
			end
			default: ram_raddr = node_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			total_q     <= SUM_BITS'(LEAVES);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_CLEAR) clr_q <= clr_q + NODE_BITS'(1);
			if ((cmd.op == OP_WUP) && status.root_next) total_q <= sum;
			if (cmd.op == OP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				req_q    <= req;
				node_q   <= {1'b1, req.leaf_index};
				tie_q    <= req.tie_bits;
				chosen_q <= (req.req_type == REQ_NONE) ? '0 : req.leaf_index;
				wt_q     <= '0;
			end
			OP_WLEAF: begin
				cur_q <= SUM_BITS'(req_q.new_weight);
				wt_q  <= req_q.new_weight;
			end
			OP_WUP: begin
				cur_q  <= sum;
				node_q <= parent;
			end
			OP_MUL: begin
				p_lo_s1 <= {{LO_BITS{1'b0}}, req_q.uniform_fraction}
				         * {{UNIFORM_BITS{1'b0}}, total_q[LO_BITS-1:0]};
				p_hi_s1 <= HI_PROD_BITS'(req_q.uniform_fraction)
				         * HI_PROD_BITS'(total_q[SUM_BITS-1:LO_BITS]);
				node_q  <= NODE_BITS'(1);
			end
			OP_SCALE: cur_q <= scaled;
			OP_DESC: begin
				cur_q  <= go_right ? (cur_q - rd_data) : cur_q;
				node_q <= node_next;
				tie_q  <= tie_q >> 1;
			end
			OP_RWAIT: begin
				wt_q     <= rd_data[WEIGHT_BITS-1:0];
				chosen_q <= node_q[LEVELS-1:0];
			end
			OP_RESULT: begin
				out_q.chosen_index <= chosen_q;
				out_q.leaf_weight  <= wt_q;
				out_q.total_weight <= total_q;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- sv/weighted_sampler_sum_tree_top.sv -----
// A write loads the leaf, makes 10 path updates and then loads the result; a read
// fetches and captures the leaf and then loads; a sample runs multiply, scale,
// 10 descent steps, leaf capture and load. One request is in flight at a time, and each
// takes longer while the receiver stalls; the result register lets a new request in
// while one waits. After reset a clearing pass loads every leaf with one and each inner
// node with its leaf count; requests are held off until it ends.
`timescale 1ns / 1ps
module weighted_sampler_sum_tree_top import wss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	cmd_t    cmd;
	status_t status;

	wss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_kind (req.req_type),
		.req_ready(req_ready),
		.cmd      (cmd),
		.status   (status)
	);

	wss_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.req      (req),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready)
	);

	// A result only appears right after the sequencer has loaded it.
	a_rsp_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd.op == OP_RESULT))
		else $error("response raised without a result load");

	// The descent never steps from a leaf.
	a_desc_inner: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DESC) |-> !status.at_leaf)
		else $error("descent step taken at a leaf");

	// Leaf weight capture always points at a leaf node.
	a_rwait_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_RWAIT) |-> status.at_leaf)
		else $error("weight captured from an inner node");

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the weighted sampler sum tree: queue-fed driver, checking monitor, tree predictor.
`timescale 1ns / 1ps
module tb_top;
	import wss_pkg::*;

	localparam int QUIET_LIMIT = 6000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int ZERO_LEAVES = 256;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	weighted_sampler_sum_tree_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// Heap-ordered copy of the tree: node 1 is the root, leaf i sits at LEAVES + i.
	logic [SUM_BITS-1:0] sum_tree [1:TREE_DEPTH-1];
	rsp_t expected_rsps[$];
	req_t pending_reqs[$];

	int reqs_queued = 0;
	int reqs_accepted = 0;
	int rsps_seen = 0;
	int errors = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 34;
	int recv_idle_pct = 53;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit req_fire = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	// Applies one request to the tree copy (a write updates it) and returns the result it should produce.
	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		int node;
		logic [UNIFORM_BITS+SUM_BITS-1:0] prod;
		logic [SUM_BITS-1:0] d;
		logic [SUM_BITS-1:0] left;
		o = '0;
		case (r.req_type)
			REQ_WRITE: begin
				node = LEAVES + int'(r.leaf_index);
				sum_tree[node] = SUM_BITS'(r.new_weight);
				for (int n = node / 2; n >= 1; n = n / 2) begin
					sum_tree[n] = sum_tree[2 * n] + sum_tree[2 * n + 1];
				end
				o.chosen_index = r.leaf_index;
				o.leaf_weight = sum_tree[node][WEIGHT_BITS-1:0];
			end
			REQ_READ: begin
				o.chosen_index = r.leaf_index;
				o.leaf_weight = sum_tree[LEAVES + int'(r.leaf_index)][WEIGHT_BITS-1:0];
			end
			REQ_SAMPLE: begin
				prod = (UNIFORM_BITS + SUM_BITS)'(r.uniform_fraction)
					* (UNIFORM_BITS + SUM_BITS)'(sum_tree[1]);
				d = prod[UNIFORM_BITS +: SUM_BITS];
				node = 1;
				for (int lvl = 0; lvl < LEVELS; lvl++) begin
					left = sum_tree[2 * node];
					if (d > left || (d == left && r.tie_bits[lvl])) begin
						d = d - left;
						node = 2 * node + 1;
					end else begin
						node = 2 * node;
					end
				end
				o.chosen_index = LEVELS'(node - LEAVES);
				o.leaf_weight = sum_tree[node][WEIGHT_BITS-1:0];
			end
			default: begin
				o.chosen_index = '0;
				o.leaf_weight = '0;
			end
		endcase
		o.total_weight = sum_tree[1];
		return o;
	endfunction

	function automatic req_t mk_req(logic [1:0] kind, int idx, logic [31:0] w,
			logic [31:0] u, logic [LEVELS-1:0] ties);
		req_t r;
		r.req_type = kind;
		r.leaf_index = LEVELS'(idx);
		r.new_weight = w;
		r.uniform_fraction = u;
		r.tie_bits = ties;
		return r;
	endfunction

	// Skewed toward small weights and a few hot leaves so that ties and repeats show up.
	function automatic req_t random_req();
		req_t r;
		int pick;
		r.leaf_index = LEVELS'($urandom_range(0, LEAVES - 1));
		r.new_weight = $urandom;
		r.uniform_fraction = $urandom;
		r.tie_bits = LEVELS'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40) r.req_type = REQ_WRITE;
		else if (pick < 60) r.req_type = REQ_READ;
		else if (pick < 97) r.req_type = REQ_SAMPLE;
		else r.req_type = REQ_NONE;
		pick = $urandom_range(0, 99);
		if (pick < 30) r.leaf_index = LEVELS'($urandom_range(0, 15));
		else if (pick < 40) r.leaf_index = LEVELS'($urandom_range(LEAVES - 16, LEAVES - 1));
		pick = $urandom_range(0, 99);
		if (pick < 15) r.new_weight = '0;
		else if (pick < 40) r.new_weight = $urandom_range(1, 4);
		else if (pick < 50) r.new_weight = '1;
		else if (pick < 60) r.new_weight = 32'h8000_0000 | $urandom_range(0, 3);
		pick = $urandom_range(0, 99);
		if (pick < 10) r.uniform_fraction = '0;
		else if (pick < 20) r.uniform_fraction = '1;
		return r;
	endfunction

	task automatic queue_req(req_t r);
		pending_reqs = {pending_reqs, r};
		reqs_queued++;
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			queue_req(random_req());
		end
	endtask

	task automatic wait_drained();
		while (reqs_accepted != reqs_queued || expected_rsps.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Driver: presents the next pending request once the previous one has been taken.
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_fire)) begin
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, plus one long hold-off that lets the block back up.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (!hold_done && rsps_seen >= 60) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Monitor: checks results against the oldest expectation, predicts accepted requests.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		bit rsp_fire;
		req_fire = req_valid && req_ready;
		rsp_fire = rsp_valid && rsp_ready;
		if (rsp_fire) begin
			rsps_seen++;
			if (expected_rsps.size() == 0) begin
				$display("%0t ERROR unexpected result: expected none, actual %h", $time, rsp);
				errors++;
			end else begin
				exp_rsp = expected_rsps.pop_front();
				if (rsp.chosen_index !== exp_rsp.chosen_index) begin
					$display("%0t ERROR chosen_index: expected %0d, actual %0d", $time,
						exp_rsp.chosen_index, rsp.chosen_index);
					errors++;
				end
				if (rsp.leaf_weight !== exp_rsp.leaf_weight) begin
					$display("%0t ERROR leaf_weight: expected %0d, actual %0d", $time,
						exp_rsp.leaf_weight, rsp.leaf_weight);
					errors++;
				end
				if (rsp.total_weight !== exp_rsp.total_weight) begin
					$display("%0t ERROR total_weight: expected %0d, actual %0d", $time,
						exp_rsp.total_weight, rsp.total_weight);
					errors++;
				end
			end
		end
		if (req_fire) begin
			expected_rsps = {expected_rsps, apply_request(req)};
			reqs_accepted++;
		end
		if (req_fire || rsp_fire) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ERROR watchdog: no request or result for %0d cycles", $time,
					quiet_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < LEAVES; i++) begin
			sum_tree[LEAVES + i] = SUM_BITS'(1);
		end
		for (int n = LEAVES - 1; n >= 1; n--) begin
			sum_tree[n] = sum_tree[2 * n] + sum_tree[2 * n + 1];
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: end leaves, fraction extremes, ties at the root, zero-weight leaves.
		queue_req(mk_req(REQ_READ, 0, $urandom, $urandom, LEVELS'($urandom)));
		queue_req(mk_req(REQ_READ, LEAVES - 1, $urandom, $urandom, LEVELS'($urandom)));
		queue_req(mk_req(REQ_SAMPLE, 0, $urandom, '0, '0));
		queue_req(mk_req(REQ_SAMPLE, 0, $urandom, '1, '1));
		queue_req(mk_req(REQ_SAMPLE, 0, $urandom, 32'h8000_0000, '0));
		queue_req(mk_req(REQ_SAMPLE, 0, $urandom, 32'h8000_0000, '1));
		queue_req(mk_req(REQ_WRITE, 0, '1, $urandom, LEVELS'($urandom)));
		queue_req(mk_req(REQ_WRITE, LEAVES - 1, '1, $urandom, LEVELS'($urandom)));
		queue_req(mk_req(REQ_READ, 0, $urandom, $urandom, LEVELS'($urandom)));
		queue_req(mk_req(REQ_SAMPLE, 0, $urandom, '1, LEVELS'($urandom)));
		queue_req(mk_req(REQ_SAMPLE, 0, $urandom, '0, LEVELS'($urandom)));
		queue_req(mk_req(REQ_NONE, $urandom_range(0, LEAVES - 1), $urandom, $urandom,
			LEVELS'($urandom)));
		queue_req(mk_req(REQ_WRITE, 0, '0, $urandom, LEVELS'($urandom)));
		queue_req(mk_req(REQ_SAMPLE, 0, $urandom, '0, '0));
		queue_req(mk_req(REQ_SAMPLE, 0, $urandom, '0, '1));
		queue_req(mk_req(REQ_WRITE, LEAVES - 1, '0, $urandom, LEVELS'($urandom)));
		queue_req(mk_req(REQ_SAMPLE, 0, $urandom, '1, '1));
		queue_req(mk_req(REQ_WRITE, LEAVES / 2, 5, $urandom, LEVELS'($urandom)));
		queue_req(mk_req(REQ_READ, LEAVES / 2, $urandom, $urandom, LEVELS'($urandom)));
		queue_req(mk_req(REQ_READ, LEAVES - 1, $urandom, $urandom, LEVELS'($urandom)));
		queue_req(mk_req(REQ_SAMPLE, 0, $urandom, $urandom, LEVELS'($urandom)));
		queue_random(200);
		wait_drained();

		send_idle_pct = 53;
		recv_idle_pct = 34;
		// Clear the lowest quarter of the leaves so that a zero draw meets zero left sums
		// on the way down and the tie bits pick the branch at most levels.
		for (int i = 0; i < ZERO_LEAVES; i++) begin
			queue_req(mk_req(REQ_WRITE, i, '0, $urandom, LEVELS'($urandom)));
		end
		for (int i = 0; i < 40; i++) begin
			if (i % 4 == 3) begin
				queue_req(mk_req(REQ_WRITE, $urandom_range(0, LEAVES - 1),
					$urandom_range(0, 3), $urandom, LEVELS'($urandom)));
			end else if (i % 2 == 0) begin
				queue_req(mk_req(REQ_SAMPLE, $urandom_range(0, LEAVES - 1), $urandom,
					'0, LEVELS'($urandom)));
			end else begin
				queue_req(mk_req(REQ_SAMPLE, $urandom_range(0, LEAVES - 1), $urandom,
					$urandom, LEVELS'($urandom)));
			end
		end
		queue_random(100);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(230);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
